// ----- hw/rtl/tkis_pkg.sv -----
`timescale 1ns / 1ps

package tkis_pkg;

  // Width of a reported position on the output stream
  localparam int unsigned POS_W = 10;

  // Width of the top_count register
  localparam int unsigned TOP_COUNT_W = 5;

  // Output tdata width: position padded to whole bytes
  localparam int unsigned OUT_DATA_W = ((POS_W + 7) / 8) * 8;

  // Controls broadcast to every ranking cell
  typedef struct packed {
    logic insert;  // place the incoming element this cycle
    logic clear;   // row ends: empty the chain after the snapshot
  } rank_ctrl_t;

  // Controls broadcast to every drain cell
  typedef struct packed {
    logic load;    // take a snapshot of the ranking chain
    logic shift;   // move one place toward the output
  } drain_ctrl_t;

endpackage

// ----- hw/rtl/tkis_rank_cell.sv -----
`timescale 1ns / 1ps

// One slot of the sorted chain. Compares its own entry with the incoming
// element; a losing entry passes down to the next slot.
module tkis_rank_cell #(
  parameter int unsigned KEY_W = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tkis_pkg::rank_ctrl_t   ctrl,
  input  logic [KEY_W-1:0]       new_key,
  input  logic [tkis_pkg::POS_W-1:0] new_pos,
  input  logic                   prev_beats,
  input  logic                   prev_valid,
  input  logic [KEY_W-1:0]       prev_key,
  input  logic [tkis_pkg::POS_W-1:0] prev_pos,
  output logic                   beats,
  output logic                   valid,
  output logic [KEY_W-1:0]       key,
  output logic [tkis_pkg::POS_W-1:0] pos,
  output logic                   ins_valid,
  output logic [tkis_pkg::POS_W-1:0] ins_pos
);
  import tkis_pkg::*;

  logic [KEY_W-1:0] ins_key;

  // Existing entry outranks the new one (ties go to the earlier position)
  assign beats = valid && (key >= new_key);

  // Contents after this cycle's insertion
  always_comb begin
    ins_valid = valid;
    ins_key   = key;
    ins_pos   = pos;
    if (ctrl.insert && !beats) begin
      if (prev_beats) begin
        ins_valid = 1'b1;
        ins_key   = new_key;
        ins_pos   = new_pos;
      end else begin
        ins_valid = prev_valid;
        ins_key   = prev_key;
        ins_pos   = prev_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= ins_valid && !ctrl.clear;
    end
  end

  always_ff @(posedge clk) begin
    key <= ins_key;
    pos <= ins_pos;
  end

endmodule

// ----- hw/rtl/tkis_drain_cell.sv -----
`timescale 1ns / 1ps

// One slot of the output shift line: loaded from the ranking chain at row
// end, then shifted toward the output one winner per transaction.
module tkis_drain_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  tkis_pkg::drain_ctrl_t      ctrl,
  input  logic                       load_valid,
  input  logic [tkis_pkg::POS_W-1:0] load_pos,
  input  logic                       up_valid,
  input  logic [tkis_pkg::POS_W-1:0] up_pos,
  output logic                       valid,
  output logic [tkis_pkg::POS_W-1:0] pos
);
  import tkis_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.load) begin
      valid <= load_valid;
    end else if (ctrl.shift) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pos <= load_pos;
    end else if (ctrl.shift) begin
      pos <= up_pos;
    end
  end

endmodule

// ----- hw/rtl/top_k_index_select_core.sv -----
`timescale 1ns / 1ps

// Channel  | Signals                        | Contents
// ---------+--------------------------------+------------------------------------
// s_axis   | s_tvalid s_tready s_tdata s_tlast | sample_value; tlast = row_end
// m_axis   | m_tvalid m_tready m_tdata m_tlast m_tuser | winner_position; tlast =
//          |                                |   run_end; tuser = row_overflow
// config   | cfg_we cfg_data                | top_count
//
// One element per cycle: every ranking cell compares in parallel and the
// chain shifts in the same cycle. At row end the chain is copied into a drain
// line that sends one winner per output transaction while the next row loads.
// A row end is held off (s_tready low while s_tlast) until the previous row's
// winners are all sent. Synchronous reset empties both chains; no clear pass.
module top_k_index_select_core #(
  parameter int unsigned K_MAX       = 16,
  parameter int unsigned ROW_MAX     = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  // config
  input  logic                                 cfg_we,
  input  logic [tkis_pkg::TOP_COUNT_W-1:0]     cfg_data,   // top_count
  // input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,    // [VALUE_WIDTH-1:0] sample_value
  input  logic                                 s_tlast,    // row_end
  // output stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [tkis_pkg::OUT_DATA_W-1:0]      m_tdata,    // [9:0] winner_position
  output logic                                 m_tlast,    // run_end
  output logic                                 m_tuser     // row_overflow
);
  import tkis_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROW_MAX + 1);
  localparam int unsigned KC_W  = $clog2(K_MAX + 1);

  logic [TOP_COUNT_W-1:0] top_count;
  logic [CNT_W-1:0]       element_count;
  logic                   overflow_seen;
  logic [KC_W-1:0]        remaining;
  logic                   out_overflow;

  logic                   s_accept;
  logic                   m_accept;
  logic                   in_range;
  logic [VALUE_WIDTH-1:0] new_key;
  logic [POS_W-1:0]       new_pos;
  logic [KC_W-1:0]        want;
  rank_ctrl_t             rctrl;
  drain_ctrl_t            dctrl;

  // Per-cell wiring, with an extra entry above/below the chain ends
  logic [K_MAX:0]         beats;
  logic [K_MAX-1:0]       r_valid;
  logic [VALUE_WIDTH-1:0] r_key   [K_MAX];
  logic [POS_W-1:0]       r_pos   [K_MAX];
  logic [K_MAX-1:0]       ins_valid;
  logic [POS_W-1:0]       ins_pos [K_MAX];
  logic [K_MAX:0]         d_valid;
  logic [POS_W-1:0]       d_pos   [K_MAX+1];

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      top_count <= TOP_COUNT_W'(1);
    end else if (cfg_we) begin
      top_count <= cfg_data;
    end
  end

  // Effective count: zero means one, capped at the chain length
  always_comb begin
    if (top_count == '0) begin
      want = KC_W'(1);
    end else if (int'(top_count) > int'(K_MAX)) begin
      want = KC_W'(K_MAX);
    end else begin
      want = KC_W'(top_count);
    end
  end

  // Handshakes
  assign s_tready = !s_tlast || !m_tvalid;
  assign s_accept = s_tvalid && s_tready;
  assign m_accept = m_tvalid && m_tready;
  assign in_range = element_count != CNT_W'(ROW_MAX);

  // Order-preserving unsigned key: flip the sign bit
  assign new_key = s_tdata[VALUE_WIDTH-1:0] ^ {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  assign new_pos = POS_W'(element_count);

  assign rctrl.insert = s_accept && in_range;
  assign rctrl.clear  = s_accept && s_tlast;
  assign dctrl.load   = s_accept && s_tlast;
  assign dctrl.shift  = m_accept;

  // Row position and overflow tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
      overflow_seen <= 1'b0;
    end else if (s_accept) begin
      if (s_tlast) begin
        element_count <= '0;
        overflow_seen <= 1'b0;
      end else if (in_range) begin
        element_count <= element_count + CNT_W'(1);
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // Ranking chain; a virtual slot above cell 0 always wins
  assign beats[0] = 1'b1;

  for (genvar i = 0; i < K_MAX; i++) begin : g_rank
    if (i == 0) begin : g_head
      tkis_rank_cell #(.KEY_W(VALUE_WIDTH)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (rctrl),
        .new_key    (new_key),
        .new_pos    (new_pos),
        .prev_beats (beats[0]),
        .prev_valid (1'b0),
        .prev_key   (new_key),
        .prev_pos   (new_pos),
        .beats      (beats[1]),
        .valid      (r_valid[0]),
        .key        (r_key[0]),
        .pos        (r_pos[0]),
        .ins_valid  (ins_valid[0]),
        .ins_pos    (ins_pos[0])
      );
    end else begin : g_body
      tkis_rank_cell #(.KEY_W(VALUE_WIDTH)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (rctrl),
        .new_key    (new_key),
        .new_pos    (new_pos),
        .prev_beats (beats[i]),
        .prev_valid (r_valid[i-1]),
        .prev_key   (r_key[i-1]),
        .prev_pos   (r_pos[i-1]),
        .beats      (beats[i+1]),
        .valid      (r_valid[i]),
        .key        (r_key[i]),
        .pos        (r_pos[i]),
        .ins_valid  (ins_valid[i]),
        .ins_pos    (ins_pos[i])
      );
    end
  end

  // Drain line; nothing enters from above the last cell
  assign d_valid[K_MAX] = 1'b0;
  assign d_pos[K_MAX]   = '0;

  for (genvar i = 0; i < K_MAX; i++) begin : g_drain
    tkis_drain_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (dctrl),
      .load_valid (ins_valid[i]),
      .load_pos   (ins_pos[i]),
      .up_valid   (d_valid[i+1]),
      .up_pos     (d_pos[i+1]),
      .valid      (d_valid[i]),
      .pos        (d_pos[i])
    );
  end

  // Winners left to send for the current row
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (dctrl.load) begin
      remaining <= want;
    end else if (m_accept) begin
      remaining <= remaining - KC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (dctrl.load) begin
      out_overflow <= overflow_seen || !in_range;
    end
  end

  // Output stream driven from the head of the drain line
  assign m_tvalid = (remaining != '0) && d_valid[0];
  assign m_tlast  = (remaining == KC_W'(1)) || !d_valid[1];
  assign m_tuser  = out_overflow;
  assign m_tdata  = OUT_DATA_W'(d_pos[0]);

endmodule
